// File: src/fnvht_pkg.sv
// fnvht_pkg: shared types and constants for the fnv1a hash table engine
// no dependencies
package fnvht_pkg;

    localparam logic [31:0] FNV_BASIS      = 32'h811C9DC5;
    localparam logic [31:0] FNV_MULTIPLIER = 32'h01000193;

    localparam logic KIND_SET = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_QUOT,
        ST_REM,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } state_t;

endpackage

// File: src/fnvht_hash.sv
// fnvht_hash: iterative fnv-1a hash, one key byte per cycle
// depends on fnvht_pkg
module fnvht_hash #(
    parameter int KEY_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] key,
    output logic        done,
    output logic [31:0] hash
);

    localparam int CW = (KEY_BYTES > 4) ? $clog2(KEY_BYTES + 1) : 3;

    logic [31:0] hash_reg, hash_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [7:0] b;

    always_comb
    begin
        b = 8'd0;
        if (cnt_reg < CW'(4))
        begin
            b = key[cnt_reg[1:0]*8 +: 8];
        end
    end

    always_comb
    begin
        hash_next = hash_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            hash_next = fnvht_pkg::FNV_BASIS;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hash_next = (hash_reg ^ {24'd0, b}) * fnvht_pkg::FNV_MULTIPLIER;
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == CW'(KEY_BYTES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
    end

    assign done = busy_reg && (cnt_reg == CW'(KEY_BYTES - 1));
    assign hash = hash_next;

endmodule

// File: src/fnvht_store.sv
// fnvht_store: bucket row memories for keys, values and valid bits
// no dependencies
module fnvht_store #(
    parameter int BUCKETS          = 16,
    parameter int SLOTS_PER_BUCKET = 4,
    parameter int BW               = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [BW-1:0]                      rd_addr,
    output logic [SLOTS_PER_BUCKET-1:0][31:0]  rd_keys,
    output logic [SLOTS_PER_BUCKET-1:0][31:0]  rd_values,
    output logic [SLOTS_PER_BUCKET-1:0]        rd_valid,
    input  logic                               wr_en,
    input  logic [BW-1:0]                      wr_addr,
    input  logic [SLOTS_PER_BUCKET-1:0]        wr_slot,
    input  logic [31:0]                        wr_key,
    input  logic [31:0]                        wr_value
);

    logic [SLOTS_PER_BUCKET-1:0][31:0] key_mem [BUCKETS];
    logic [SLOTS_PER_BUCKET-1:0][31:0] val_mem [BUCKETS];
    logic [SLOTS_PER_BUCKET-1:0] valid_reg [BUCKETS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int s = 0; s < SLOTS_PER_BUCKET; s++)
            begin
                if (wr_slot[s])
                begin
                    key_mem[wr_addr][s] <= wr_key;
                    val_mem[wr_addr][s] <= wr_value;
                end
            end
        end
        rd_keys   <= key_mem[rd_addr];
        rd_values <= val_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
            begin
                valid_reg[i] <= '0;
            end
            rd_valid <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= valid_reg[wr_addr] | wr_slot;
            end
            rd_valid <= valid_reg[rd_addr];
        end
    end

endmodule

// File: src/fnv1a_hash_table_engine.sv
// fnv1a_hash_table_engine: fnv-1a hashed key-value table with fixed bucket slots
// no new request is taken until the last one has passed the byte-serial hash loop, the
// bucket reduction, the row read and write-back and the output state
// the next request is taken in the cycle the result is shown, even while it is stalled
// reset clears all valid bits and the entry count at once; keys and values are not cleared
// depends on fnvht_pkg, fnvht_hash, fnvht_store
module fnv1a_hash_table_engine #(
    parameter int BUCKETS          = 16,
    parameter int SLOTS_PER_BUCKET = 4,
    parameter int KEY_BYTES        = 4,
    parameter int VALUE_BYTES      = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] key,
    input  logic [31:0] value,
    input  logic [31:0] default_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_value,
    output logic        hit,
    output logic        dropped,
    output logic [6:0]  entry_count
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int TOTAL = BUCKETS * SLOTS_PER_BUCKET;
    localparam int CNTW = $clog2(TOTAL + 1);
    localparam logic [31:0] KMASK = (KEY_BYTES >= 4) ? 32'hFFFFFFFF
                                    : ((32'd1 << (8 * KEY_BYTES)) - 32'd1);
    localparam logic [31:0] VMASK = (VALUE_BYTES >= 4) ? 32'hFFFFFFFF
                                    : ((32'd1 << (8 * VALUE_BYTES)) - 32'd1);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / BUCKETS);

    fnvht_pkg::state_t state_reg, state_next;
    logic        kind_reg;
    logic [31:0] key_reg, value_reg, dflt_reg;
    logic [BW-1:0] bucket_reg;
    logic [CNTW-1:0] count_reg, count_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] res_reg, res_next;
    logic        hit_reg, hit_next, drop_reg, drop_next;

    logic        take;
    logic        hash_start, hash_done;
    logic [31:0] hash;
    logic [31:0] hval_reg, quot_reg;
    logic [63:0] recip_prod;
    logic [31:0] rem_raw, rem_fix;
    logic [SLOTS_PER_BUCKET-1:0][31:0] rd_keys, rd_values;
    logic [SLOTS_PER_BUCKET-1:0] rd_valid;
    logic        wr_en;
    logic [SLOTS_PER_BUCKET-1:0] wr_slot;
    logic [SLOTS_PER_BUCKET-1:0] match, free_one;
    logic        found, has_free;
    logic [31:0] found_val;

    assign take = in_valid && !in_stall;
    assign hash_start = take;

    // bucket index by reciprocal multiply, then one correcting subtract
    always_comb
    begin
        recip_prod = 64'(hval_reg) * 64'(RECIP);
        rem_raw    = hval_reg - quot_reg * 32'(BUCKETS);
        rem_fix    = (rem_raw >= 32'(BUCKETS)) ? rem_raw - 32'(BUCKETS) : rem_raw;
    end

    fnvht_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_reg),
        .done  (hash_done),
        .hash  (hash)
    );

    fnvht_store #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .BW               (BW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (bucket_reg),
        .rd_keys   (rd_keys),
        .rd_values (rd_values),
        .rd_valid  (rd_valid),
        .wr_en     (wr_en),
        .wr_addr   (bucket_reg),
        .wr_slot   (wr_slot),
        .wr_key    (key_reg),
        .wr_value  (value_reg)
    );

    always_comb
    begin
        found     = 1'b0;
        has_free  = 1'b0;
        found_val = '0;
        match     = '0;
        free_one  = '0;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            if (rd_valid[s] && rd_keys[s] == key_reg && !found)
            begin
                found     = 1'b1;
                match[s]  = 1'b1;
                found_val = rd_values[s];
            end
            if (!rd_valid[s] && !has_free)
            begin
                has_free    = 1'b1;
                free_one[s] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fnvht_pkg::ST_IDLE:   if (take) state_next = fnvht_pkg::ST_HASH;
            fnvht_pkg::ST_HASH:   if (hash_done) state_next = fnvht_pkg::ST_QUOT;
            fnvht_pkg::ST_QUOT:   state_next = fnvht_pkg::ST_REM;
            fnvht_pkg::ST_REM:    state_next = fnvht_pkg::ST_READ;
            fnvht_pkg::ST_READ:   state_next = fnvht_pkg::ST_UPDATE;
            fnvht_pkg::ST_UPDATE: state_next = fnvht_pkg::ST_OUT;
            fnvht_pkg::ST_OUT:    if (!out_valid_reg || !out_stall)
                                      state_next = fnvht_pkg::ST_IDLE;
            default:              state_next = fnvht_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall       = (state_reg != fnvht_pkg::ST_IDLE);
        wr_en          = 1'b0;
        wr_slot        = '0;
        count_next     = count_reg;
        res_next       = res_reg;
        hit_next       = hit_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == fnvht_pkg::ST_UPDATE)
        begin
            hit_next  = found;
            drop_next = 1'b0;
            if (kind_reg == fnvht_pkg::KIND_SET)
            begin
                if (found)
                begin
                    wr_en    = 1'b1;
                    wr_slot  = match;
                    res_next = value_reg;
                end
                else if (has_free)
                begin
                    wr_en      = 1'b1;
                    wr_slot    = free_one;
                    res_next   = value_reg;
                    count_next = count_reg + CNTW'(1);
                end
                else
                begin
                    res_next  = '0;
                    drop_next = 1'b1;
                end
            end
            else
            begin
                res_next = found ? found_val : dflt_reg;
            end
        end
        if (state_reg == fnvht_pkg::ST_OUT && (!out_valid_reg || !out_stall))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fnvht_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    logic [31:0] res_hold_reg;
    logic        hit_hold_reg, drop_hold_reg;
    logic [CNTW-1:0] cnt_hold_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= kind;
            key_reg   <= key & KMASK;
            value_reg <= value & VMASK;
            dflt_reg  <= default_value;
        end
        if (hash_done)
        begin
            hval_reg <= hash;
        end
        if (state_reg == fnvht_pkg::ST_QUOT)
        begin
            quot_reg <= recip_prod[63:32];
        end
        if (state_reg == fnvht_pkg::ST_REM)
        begin
            bucket_reg <= rem_fix[BW-1:0];
        end
        res_reg  <= res_next;
        hit_reg  <= hit_next;
        drop_reg <= drop_next;
        if (state_reg == fnvht_pkg::ST_OUT && (!out_valid_reg || !out_stall))
        begin
            res_hold_reg  <= res_reg;
            hit_hold_reg  <= hit_reg;
            drop_hold_reg <= drop_reg;
            cnt_hold_reg  <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_hold_reg;
    assign hit          = hit_hold_reg;
    assign dropped      = drop_hold_reg;
    assign entry_count  = (CNTW > 7 && cnt_hold_reg > 127) ? 7'd127 : 7'(cnt_hold_reg);

endmodule

// File: verif/fnv1a_hash_table_engine_tb.sv
// fnv1a_hash_table_engine_tb: self-checking testbench for the fnv1a hash table engine
// predicts every result from its own table copy and checks transfers on the output side
// depends on fnvht_pkg and the fnv1a_hash_table_engine rtl
module fnv1a_hash_table_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKETS    = 16;
    localparam int SLOTS      = 4;
    localparam int TOTAL      = BUCKETS * SLOTS;
    localparam int WDOG_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] result_value;
        logic        hit;
        logic        dropped;
        logic [6:0]  entry_count;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] default_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_value;
    logic        hit;
    logic        dropped;
    logic [6:0]  entry_count;

    logic [31:0] tbl_keys [TOTAL];
    logic [31:0] tbl_values [TOTAL];
    logic        tbl_valid [TOTAL];
    int          tbl_count;
    answer_t     pending_answers[$];
    logic [31:0] used_keys[$];
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;

    fnv1a_hash_table_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .key(key), .value(value), .default_value(default_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_value(result_value), .hit(hit), .dropped(dropped),
        .entry_count(entry_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [31:0] fnv1a32(input logic [31:0] k);
        logic [31:0] h;
        h = fnvht_pkg::FNV_BASIS;
        for (int i = 0; i < 4; i++)
        begin
            h = (h ^ {24'd0, k[8*i +: 8]}) * fnvht_pkg::FNV_MULTIPLIER;
        end
        return h;
    endfunction

    function automatic answer_t table_access(input logic op, input logic [31:0] k,
                                             input logic [31:0] v, input logic [31:0] dflt);
        answer_t a;
        int base;
        int found;
        int free_idx;
        a = '0;
        base = (fnv1a32(k) % BUCKETS) * SLOTS;
        found = -1;
        free_idx = -1;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (tbl_valid[base + s])
            begin
                if (found < 0 && tbl_keys[base + s] == k)
                    found = base + s;
            end
            else if (free_idx < 0)
                free_idx = base + s;
        end
        if (op == fnvht_pkg::KIND_SET)
        begin
            if (found >= 0)
            begin
                tbl_values[found] = v;
                a.result_value = v;
                a.hit = 1'b1;
            end
            else if (free_idx >= 0)
            begin
                tbl_keys[free_idx] = k;
                tbl_values[free_idx] = v;
                tbl_valid[free_idx] = 1'b1;
                tbl_count++;
                a.result_value = v;
            end
            else
                a.dropped = 1'b1;
        end
        else
        begin
            if (found >= 0)
            begin
                a.result_value = tbl_values[found];
                a.hit = 1'b1;
            end
            else
                a.result_value = dflt;
        end
        a.entry_count = (tbl_count > 127) ? 7'd127 : tbl_count[6:0];
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_request(input logic op, input logic [31:0] k,
                                input logic [31:0] v, input logic [31:0] dflt);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        key <= k;
        value <= v;
        default_value <= dflt;
        do
            @(posedge clk);
        while (in_stall);
        pending_answers.push_back(table_access(op, k, v, dflt));
        if (op == fnvht_pkg::KIND_SET)
            used_keys.push_back(k);
    endtask

    function automatic logic [31:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return $urandom();
    endfunction

    task automatic test_directed();
        send_request(fnvht_pkg::KIND_GET, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(fnvht_pkg::KIND_SET, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);
        send_request(fnvht_pkg::KIND_SET, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(fnvht_pkg::KIND_GET, 32'hFFFF_FFFF, 32'h1234_5678, 32'hAAAA_5555);
        send_request(fnvht_pkg::KIND_GET, 32'h0000_0000, 32'h0, 32'h5555_AAAA);
        send_request(fnvht_pkg::KIND_SET, 32'h0000_0000, 32'hDEAD_BEEF, 32'h0);
        send_request(fnvht_pkg::KIND_GET, 32'h0000_0000, 32'h0, 32'h0);
        send_request(fnvht_pkg::KIND_GET, 32'h8000_0001, 32'h0, 32'hFFFF_FFFF);
    endtask

    // fill one bucket past its slots to reach the full-bucket drop
    task automatic test_full_bucket();
        logic [31:0] k;
        logic [31:0] target;
        int n;
        target = fnv1a32(32'h0000_1000) % BUCKETS;
        n = 0;
        k = 32'h0000_1000;
        while (n < SLOTS + 2)
        begin
            if (fnv1a32(k) % BUCKETS == target)
            begin
                send_request(fnvht_pkg::KIND_SET, k, $urandom(), $urandom());
                n++;
            end
            k++;
        end
        send_request(fnvht_pkg::KIND_GET, 32'h0000_1000, $urandom(), $urandom());
        send_request(fnvht_pkg::KIND_SET, 32'h0000_1000, $urandom(), $urandom());
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(1'($urandom_range(0, 1)), pick_key(), $urandom(), $urandom());
    endtask

    // output side stall and check
    initial
    begin
        int gap;
        answer_t want;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_answers.size() == 0)
            begin
                $display("unexpected result transfer at %0t", $realtime);
                mismatches++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result_value !== want.result_value)
                    report_mismatch("result_value", result_value, want.result_value);
                if (hit !== want.hit)
                    report_mismatch("hit", {31'd0, hit}, {31'd0, want.hit});
                if (dropped !== want.dropped)
                    report_mismatch("dropped", {31'd0, dropped}, {31'd0, want.dropped});
                if (entry_count !== want.entry_count)
                    report_mismatch("entry_count", {25'd0, entry_count},
                                    {25'd0, want.entry_count});
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = fnvht_pkg::KIND_SET;
        key = '0;
        value = '0;
        default_value = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        tbl_count = 0;
        for (int i = 0; i < TOTAL; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_keys[i] = '0;
            tbl_values[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_bucket();
        test_random(1000);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
